/* hw/rtl/matp_pkg.sv */
`timescale 1ns / 1ps

package matp_pkg;

  localparam int unsigned StatusW = 4;
  localparam int unsigned PhaseW  = 4;
  localparam int unsigned WordW   = 32;

  // Result status codes.
  localparam logic [StatusW-1:0] ST_BUSY         = 4'd0;
  localparam logic [StatusW-1:0] ST_DONE         = 4'd1;
  localparam logic [StatusW-1:0] ST_SHORT_HDR    = 4'd2;
  localparam logic [StatusW-1:0] ST_OVERRUN      = 4'd3;
  localparam logic [StatusW-1:0] ST_ODD_ACK      = 4'd4;
  localparam logic [StatusW-1:0] ST_BAD_COUNT    = 4'd5;
  localparam logic [StatusW-1:0] ST_BAD_LOOK_LEN = 4'd6;
  localparam logic [StatusW-1:0] ST_UNKNOWN_TYPE = 4'd7;
  localparam logic [StatusW-1:0] ST_SURPLUS      = 4'd8;

  // Parser phases. A halted parser sits at PH_HALT_BASE plus its error status.
  localparam logic [PhaseW-1:0] PH_IDLE      = 4'd0;
  localparam logic [PhaseW-1:0] PH_ETYPE     = 4'd1;
  localparam logic [PhaseW-1:0] PH_ELEN      = 4'd2;
  localparam logic [PhaseW-1:0] PH_ATYPE     = 4'd3;
  localparam logic [PhaseW-1:0] PH_ACOUNT    = 4'd4;
  localparam logic [PhaseW-1:0] PH_LOOK      = 4'd5;
  localparam logic [PhaseW-1:0] PH_DONE      = 4'd6;
  localparam logic [PhaseW-1:0] PH_HALT_BASE = 4'd6;

  // Entry type classes kept between the type byte and the length byte.
  localparam logic [1:0] ECLS_OTHER = 2'd0;
  localparam logic [1:0] ECLS_ACK   = 2'd1;
  localparam logic [1:0] ECLS_LOOK  = 2'd2;

  localparam logic [7:0] ENTRY_TYPE_ACK  = 8'h01;
  localparam logic [7:0] ENTRY_TYPE_LOOK = 8'h02;
  localparam logic [7:0] LOOK_LEN        = 8'd6;
  localparam logic [7:0] ITEM_CMD        = 8'h01;
  localparam logic [7:0] ITEM_DATA_A     = 8'h02;
  localparam logic [7:0] ITEM_DATA_B     = 8'h05;
  localparam logic [7:0] ACK_COUNT_ONE   = 8'h01;
  localparam logic [7:0] MARK_OPEN       = 8'h55;
  localparam logic [7:0] MARK_CLOSE      = 8'hAA;

  localparam logic FUNC_START = 1'b0;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic [7:0]        list_rem;
    logic [1:0]        entry_cls;
    logic [7:0]        entry_rem;
    logic [2:0]        byte_idx;
    logic              open_ok;
    logic [WordW-1:0]  gathered;
    logic [WordW-1:0]  held;
  } parse_state_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic               cmd_ack;
    logic               data_ack;
    logic               look_valid;
  } parse_flags_t;

endpackage

/* hw/rtl/matp_step.sv */
`timescale 1ns / 1ps

module matp_step
  import matp_pkg::*;
(
  input  parse_state_t state_i,
  input  logic         func_i,
  input  logic [7:0]   trailer_len_i,
  input  logic [7:0]   data_byte_i,
  output parse_state_t state_o,
  output parse_flags_t flags_o
);

  logic [7:0] list_less2;
  logic [7:0] entry_after;
  logic [7:0] list_seen;

  always_comb begin
    state_o     = state_i;
    flags_o     = '0;
    list_less2  = state_i.list_rem - 8'd2;
    entry_after = state_i.entry_rem;
    list_seen   = state_i.list_rem;

    if (func_i == FUNC_START) begin
      state_o.list_rem  = trailer_len_i;
      state_o.entry_cls = ECLS_OTHER;
      state_o.entry_rem = '0;
      state_o.byte_idx  = '0;
      state_o.open_ok   = 1'b0;
      state_o.gathered  = '0;
      list_seen         = trailer_len_i;
      entry_after       = '0;
    end

    if (func_i == FUNC_START) begin
      // Handled with the end-of-entry decision below.
    end else if (state_i.phase > PH_HALT_BASE + ST_DONE &&
                 state_i.phase <= PH_HALT_BASE + ST_SURPLUS) begin
      flags_o.status = state_i.phase - PH_HALT_BASE;
    end else begin
      case (state_i.phase)
        PH_ETYPE: begin
          if (data_byte_i == ENTRY_TYPE_ACK) begin
            state_o.entry_cls = ECLS_ACK;
          end else if (data_byte_i == ENTRY_TYPE_LOOK) begin
            state_o.entry_cls = ECLS_LOOK;
          end else begin
            state_o.entry_cls = ECLS_OTHER;
          end
          state_o.phase = PH_ELEN;
        end
        PH_ELEN: begin
          state_o.list_rem = list_less2;
          if (data_byte_i > list_less2) begin
            flags_o.status = ST_OVERRUN;
          end else begin
            state_o.list_rem  = list_less2 - data_byte_i;
            state_o.entry_rem = data_byte_i;
            list_seen         = list_less2 - data_byte_i;
            entry_after       = data_byte_i;
            case (state_i.entry_cls)
              ECLS_ACK: begin
                // Pair boundary decision is taken below.
              end
              ECLS_LOOK: begin
                if (data_byte_i != LOOK_LEN) begin
                  flags_o.status = ST_BAD_LOOK_LEN;
                end else begin
                  state_o.byte_idx = '0;
                  state_o.phase    = PH_LOOK;
                end
              end
              default: begin
                flags_o.status = ST_UNKNOWN_TYPE;
              end
            endcase
          end
        end
        PH_ATYPE: begin
          state_o.entry_rem = state_i.entry_rem - 8'd2;
          if (data_byte_i == ITEM_CMD) begin
            flags_o.cmd_ack = 1'b1;
          end else if (data_byte_i == ITEM_DATA_A || data_byte_i == ITEM_DATA_B) begin
            flags_o.data_ack = 1'b1;
          end
          state_o.phase = PH_ACOUNT;
        end
        PH_ACOUNT: begin
          if (data_byte_i != ACK_COUNT_ONE) begin
            flags_o.status = ST_BAD_COUNT;
          end
        end
        PH_LOOK: begin
          case (state_i.byte_idx)
            3'd0: begin
              state_o.open_ok  = (data_byte_i == MARK_OPEN);
              state_o.gathered = '0;
              state_o.byte_idx = 3'd1;
            end
            3'd1: begin
              state_o.gathered[7:0] = data_byte_i;
              state_o.byte_idx      = 3'd2;
            end
            3'd2: begin
              state_o.gathered[15:8] = data_byte_i;
              state_o.byte_idx       = 3'd3;
            end
            3'd3: begin
              state_o.gathered[23:16] = data_byte_i;
              state_o.byte_idx        = 3'd4;
            end
            3'd4: begin
              state_o.gathered[31:24] = data_byte_i;
              state_o.byte_idx        = 3'd5;
            end
            default: begin
              if (state_i.open_ok && data_byte_i == MARK_CLOSE) begin
                state_o.held       = state_i.gathered;
                flags_o.look_valid = 1'b1;
              end
              state_o.byte_idx  = '0;
              state_o.entry_rem = '0;
              entry_after       = '0;
            end
          endcase
        end
        default: begin
          flags_o.status = ST_SURPLUS;
        end
      endcase
    end

    // Work out whether this byte closes an entry or an ack pair, and what follows.
    begin : boundary
      logic at_entry_end;
      logic at_pair_end;
      at_entry_end = 1'b0;
      at_pair_end  = 1'b0;
      if (func_i == FUNC_START) begin
        at_entry_end = 1'b1;
      end else if (flags_o.status == ST_BUSY) begin
        if (state_i.phase == PH_ELEN && state_i.entry_cls == ECLS_ACK) begin
          at_pair_end = 1'b1;
        end else if (state_i.phase == PH_ACOUNT) begin
          at_pair_end = 1'b1;
        end else if (state_i.phase == PH_LOOK && state_i.byte_idx > 3'd4) begin
          at_entry_end = 1'b1;
        end
      end

      if (at_pair_end) begin
        if (entry_after == 8'd0) begin
          at_entry_end = 1'b1;
        end else if (entry_after == 8'd1) begin
          flags_o.status = ST_ODD_ACK;
        end else begin
          state_o.phase = PH_ATYPE;
        end
      end

      if (at_entry_end) begin
        if (list_seen == 8'd0) begin
          state_o.phase  = PH_DONE;
          flags_o.status = ST_DONE;
        end else if (list_seen == 8'd1) begin
          flags_o.status = ST_SHORT_HDR;
        end else begin
          state_o.phase = PH_ETYPE;
        end
      end
    end

    // Any error status parks the parser in its halt phase.
    if (flags_o.status > ST_DONE) begin
      state_o.phase = PH_HALT_BASE + flags_o.status;
    end
  end

endmodule

/* hw/rtl/mailbox_ack_trailer_parser.sv */
`timescale 1ns / 1ps

// Mailbox acknowledgement trailer parser. Each accepted request is one start
// (func_i low, trailer_len_i) or one trailer byte (func_i high, data_byte_i),
// and produces exactly one result in the output register. The parser takes
// a request every cycle: the only bound on rate is that single output
// register, which accepts a new request whenever it is empty or its result
// is taken in the same cycle. Pulses are per byte; lookahead_value_o
// always shows the latest framed lookahead word. After an error the parser
// repeats its status until the next start; a byte after done reports surplus.
module mailbox_ack_trailer_parser
  import matp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               func_i,
  input  logic [7:0]         trailer_len_i,
  input  logic [7:0]         data_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [StatusW-1:0] status_o,
  output logic               cmd_ack_o,
  output logic               data_ack_o,
  output logic               lookahead_valid_o,
  output logic [WordW-1:0]   lookahead_value_o
);

  parse_state_t state_q, state_d;
  parse_flags_t flags_d, flags_q;
  logic [WordW-1:0] value_q;
  logic out_valid_q;
  logic accept;

  matp_step u_step (
    .state_i      (state_q),
    .func_i       (func_i),
    .trailer_len_i(trailer_len_i),
    .data_byte_i  (data_byte_i),
    .state_o      (state_d),
    .flags_o      (flags_d)
  );

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // The all-zero state is the idle phase with every counter cleared.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        state_q <= state_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      flags_q <= flags_d;
      value_q <= state_d.held;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = flags_q.status;
  assign cmd_ack_o         = flags_q.cmd_ack;
  assign data_ack_o        = flags_q.data_ack;
  assign lookahead_valid_o = flags_q.look_valid;
  assign lookahead_value_o = value_q;

endmodule
